>>> src/tslk_pkg.sv
// tslk_pkg: shared types and constants for the three-level sparse char table lookup.
// No dependencies; imported by tslk_addr_unit and the top level.
package tslk_pkg;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LVL1,
        ST_LVL2,
        ST_LVL3,
        ST_LEAF,
        ST_DONE
    } tslk_state_t;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_CLASS = 2'd1;
    localparam logic [1:0] FUNC_XLATE = 2'd2;

    localparam logic [2:0] CFG_LEVEL1_SHIFT = 3'd0;
    localparam logic [2:0] CFG_LEVEL1_BOUND = 3'd1;
    localparam logic [2:0] CFG_LEVEL2_SHIFT = 3'd2;
    localparam logic [2:0] CFG_LEVEL2_MASK  = 3'd3;
    localparam logic [2:0] CFG_LEVEL3_MASK  = 3'd4;

    localparam logic [29:0] LEVEL1_BASE  = 30'd5;
    localparam logic [4:0]  BIT_SEL_MASK = 5'h1f;
    localparam logic [4:0]  CLASS_SHIFT  = 5'd5;

    // request to the shared index/address unit
    typedef struct packed
    {
        logic [29:0] base;
        logic [4:0]  shamt;
        logic [31:0] mask;
    } tslk_addr_req_t;

    // answer from the shared index/address unit
    typedef struct packed
    {
        logic [31:0] idx;
        logic [32:0] sum;
        logic        in_range;
    } tslk_addr_rsp_t;

endpackage

>>> src/tslk_addr_unit.sv
// tslk_addr_unit: shared shifter, masker, adder and range compare for all table levels.
// Depends on tslk_pkg.
module tslk_addr_unit
    import tslk_pkg::*;
#(
    parameter int TABLE_WORDS = 4096
)
(
    input  logic [31:0]    code_point,
    input  tslk_addr_req_t req,
    output tslk_addr_rsp_t rsp
);

    logic [31:0] shifted;

    always_comb
    begin
        shifted      = code_point >> req.shamt;
        rsp.idx      = shifted & req.mask;
        rsp.sum      = 33'(req.base) + 33'(rsp.idx);
        rsp.in_range = rsp.sum < 33'(TABLE_WORDS);
    end

endmodule

>>> src/tslk_table_ram.sv
// tslk_table_ram: single-port table memory, registered read data.
// No dependencies.
module tslk_table_ram
#(
    parameter int TABLE_WORDS = 4096,
    parameter int AW          = 12
)
(
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [TABLE_WORDS];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/three_level_sparse_char_table_lookup.sv
// three_level_sparse_char_table_lookup: top level, sequencer, config registers, output word.
// Depends on tslk_pkg, tslk_addr_unit and tslk_table_ram.
//
// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: code_point, word_address, word_data
//                                             tuser: func
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: result_value; tuser: leaf_found
// cfg      in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// A load or unused word goes straight from idle to done; a query makes three dependent
// reads of the single-port table memory, each through the shared address unit, then a leaf
// step. A miss at any level ends the walk early. rst_n clears sequencer, config registers
// and output valid; the table is not cleared. The next word is taken while a result waits;
// the sequencer holds in its last state while m_axis stalls. cfg_ready is always high.
module three_level_sparse_char_table_lookup
    import tslk_pkg::*;
#(
    parameter int TABLE_WORDS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // [31:0] code_point, [43:32] word_address,
                                        // [75:44] word_data, [79:76] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_value
    output logic        m_axis_tuser,   // [0] leaf_found
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int AW = $clog2(TABLE_WORDS);

    tslk_state_t state_reg, state_next;

    logic [4:0]  level1_shift_reg;
    logic [11:0] level1_bound_reg;
    logic [4:0]  level2_shift_reg;
    logic [11:0] level2_mask_reg;
    logic [11:0] level3_mask_reg;

    logic [1:0]  func_reg;
    logic [31:0] cp_reg;
    logic [31:0] res_value_reg;
    logic        res_found_reg;
    logic [31:0] out_value_reg;
    logic        out_found_reg;
    logic        out_valid_reg;

    tslk_addr_req_t addr_req;
    tslk_addr_rsp_t addr_rsp;

    logic          in_acc;
    logic          out_free;
    logic          walk_ok;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_rdata;
    logic [31:0]   waddr_ext;
    logic          waddr_ok;
    logic [31:0]   miss_value;
    logic [31:0]   leaf_value;
    logic [31:0]   leaf_shifted;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign waddr_ext = 32'(s_axis_tdata[43:32]);
    assign waddr_ok  = waddr_ext < 32'(TABLE_WORDS);
    assign cfg_ready = 1'b1;

    tslk_addr_unit #(.TABLE_WORDS(TABLE_WORDS)) u_addr
    (
        .code_point (cp_reg),
        .req        (addr_req),
        .rsp        (addr_rsp)
    );

    tslk_table_ram #(.TABLE_WORDS(TABLE_WORDS), .AW(AW)) u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (s_axis_tdata[75:44]),
        .rdata (ram_rdata)
    );

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        addr_req      = '0;
        walk_ok       = 1'b0;
        ram_we        = in_acc && (s_axis_tuser == FUNC_WRITE) && waddr_ok;
        case (state_reg)
            ST_LVL1:
            begin
                addr_req.base  = LEVEL1_BASE;
                addr_req.shamt = level1_shift_reg;
                addr_req.mask  = '1;
                walk_ok        = (addr_rsp.idx < 32'(level1_bound_reg)) && addr_rsp.in_range;
            end
            ST_LVL2:
            begin
                addr_req.base  = ram_rdata[31:2];
                addr_req.shamt = level2_shift_reg;
                addr_req.mask  = 32'(level2_mask_reg);
                walk_ok        = (ram_rdata != '0) && addr_rsp.in_range;
            end
            ST_LVL3:
            begin
                addr_req.base  = ram_rdata[31:2];
                addr_req.shamt = (func_reg == FUNC_CLASS) ? CLASS_SHIFT : '0;
                addr_req.mask  = 32'(level3_mask_reg);
                walk_ok        = (ram_rdata != '0) && addr_rsp.in_range;
            end
            default:
            begin
                addr_req = '0;
            end
        endcase
        ram_re   = walk_ok;
        ram_addr = ram_we ? waddr_ext[AW-1:0] : addr_rsp.sum[AW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser == FUNC_CLASS || s_axis_tuser == FUNC_XLATE)
                    begin
                        state_next = ST_LVL1;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LVL1: state_next = walk_ok ? ST_LVL2 : ST_DONE;
            ST_LVL2: state_next = walk_ok ? ST_LVL3 : ST_DONE;
            ST_LVL3: state_next = walk_ok ? ST_LEAF : ST_DONE;
            ST_LEAF: state_next = ST_DONE;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign miss_value   = (func_reg == FUNC_XLATE) ? cp_reg : '0;
    assign leaf_shifted = ram_rdata >> (cp_reg[4:0] & BIT_SEL_MASK);
    assign leaf_value   = (func_reg == FUNC_CLASS) ? {31'd0, leaf_shifted[0]}
                                                   : cp_reg + ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            level1_shift_reg <= '0;
            level1_bound_reg <= '0;
            level2_shift_reg <= '0;
            level2_mask_reg  <= '0;
            level3_mask_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LEVEL1_SHIFT: level1_shift_reg <= cfg_data[4:0];
                    CFG_LEVEL1_BOUND: level1_bound_reg <= cfg_data;
                    CFG_LEVEL2_SHIFT: level2_shift_reg <= cfg_data[4:0];
                    CFG_LEVEL2_MASK:  level2_mask_reg  <= cfg_data;
                    CFG_LEVEL3_MASK:  level3_mask_reg  <= cfg_data;
                    default:          ;
                endcase
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg      <= s_axis_tuser;
            cp_reg        <= s_axis_tdata[31:0];
            res_value_reg <= '0;
            res_found_reg <= 1'b0;
        end
        else if ((state_reg == ST_LVL1 || state_reg == ST_LVL2 || state_reg == ST_LVL3)
                 && !walk_ok)
        begin
            res_value_reg <= miss_value;
            res_found_reg <= 1'b0;
        end
        else if (state_reg == ST_LEAF)
        begin
            res_value_reg <= leaf_value;
            res_found_reg <= 1'b1;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_value_reg <= res_value_reg;
            out_found_reg <= res_found_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_found_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_DONE)
        else $error("result word raised outside the done state");

    a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (state_reg == ST_LVL1 || state_reg == ST_LVL2 || state_reg == ST_LVL3))
        else $error("table read issued outside a walk level");

    a_leaf_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LEAF |-> $past(ram_re) && $past(state_reg) == ST_LVL3)
        else $error("leaf state entered without a third-level read");

endmodule
